[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/flh_pkg.sv]
package flh_pkg;

  localparam int TableEntriesDef = 1024;
  localparam int HistBinsDef     = 16;
  localparam int CountWidthDef   = 32;

  localparam int TimeW   = 64;
  localparam int FlowW   = 32;
  localparam int WidthW  = 40;
  localparam int DropW   = 8;
  localparam int ClampW  = 4;
  localparam int StatusW = 3;
  localparam int BinW    = 4;
  localparam int TotalW  = 32;
  localparam int CfgW    = 40;
  localparam int CfgIdxW = 2;

  localparam logic [WidthW-1:0] BinWidthRst = WidthW'(100000000);
  localparam logic [DropW-1:0]  DropRst     = DropW'(50);
  localparam logic [ClampW-1:0] ClampRst    = ClampW'(10);

  localparam logic [CfgIdxW-1:0] CfgBinWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDrop     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClamp    = 2'd2;

  localparam logic [StatusW-1:0] StStarted   = 3'd0;
  localparam logic [StatusW-1:0] StPresent   = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StUnmatched = 3'd3;
  localparam logic [StatusW-1:0] StRange     = 3'd4;
  localparam logic [StatusW-1:0] StCounted   = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input beat
    logic scan_start; // reset scan pointer
    logic scan_step;  // advance scan pointer
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic write_slot; // write new entry
    logic free_slot;  // clear valid of matched entry
    logic hist_rd;    // read bin counter
    logic hist_wr;    // write back counter, capture result
    logic set_status; // capture a non-counted status
    logic [StatusW-1:0] status;
  } flh_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clearing;   // valid bits still being cleared after reset
    logic op_end;
    logic scan_done;  // pointer past last entry, no read pending
    logic rd_ok;      // registered read data is valid for the compare
    logic match;
    logic have_free;
    logic div_done;
    logic out_range;
  } flh_stat_t;

endpackage

[sv/flow_latency_histogram_unit.sv]
// Each event scans the whole table, one entry a cycle, before its result beat;
// a matched end event then runs the divider and, when it is counted, a histogram
// read and a histogram write.
// Throughput: one event at a time; the next beat can be taken in the cycle
// after the result beat leaves. Reset (rst, synchronous): bin counters and config
// to defaults, then entry valid bits cleared one a cycle with the input stalled.
module flow_latency_histogram_unit import flh_pkg::*; #(
  parameter int TableEntries = TableEntriesDef,
  parameter int HistBins     = HistBinsDef,
  parameter int CountWidth   = CountWidthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [FlowW-1:0]   flow_id,
  input  logic [TimeW-1:0]   event_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [StatusW-1:0] status,
  output logic [BinW-1:0]    bin_index,
  output logic [TotalW-1:0]  bin_total
);

  logic [WidthW-1:0] bin_width_ns;
  logic [DropW-1:0]  drop_above_bin;
  logic [ClampW-1:0] clamp_bin;
  flh_cmd_t  cmd;
  flh_stat_t stat;

  // Config registers; unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width_ns   <= BinWidthRst;
      drop_above_bin <= DropRst;
      clamp_bin      <= ClampRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgBinWidth: bin_width_ns   <= cfg_data[WidthW-1:0];
        CfgDrop:     drop_above_bin <= cfg_data[DropW-1:0];
        CfgClamp:    clamp_bin      <= cfg_data[ClampW-1:0];
        default: ;
      endcase
    end
  end

  flh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  flh_datapath #(
    .TableEntries(TableEntries), .HistBins(HistBins), .CountWidth(CountWidth)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_opcode(opcode), .in_flow_id(flow_id), .in_event_time(event_time),
    .bin_width_ns(bin_width_ns), .drop_above_bin(drop_above_bin),
    .clamp_bin(clamp_bin), .res_status(status), .res_bin(bin_index),
    .res_total(bin_total)
  );

endmodule

[sv/flh_ram.sv]
module flh_ram import flh_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/flh_datapath.sv]
`include "assert_macros.svh"

module flh_datapath import flh_pkg::*; #(
  parameter int TableEntries = TableEntriesDef,
  parameter int HistBins     = HistBinsDef,
  parameter int CountWidth   = CountWidthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  flh_cmd_t           cmd,
  output flh_stat_t          stat,
  input  logic               in_opcode,
  input  logic [FlowW-1:0]   in_flow_id,
  input  logic [TimeW-1:0]   in_event_time,
  input  logic [WidthW-1:0]  bin_width_ns,
  input  logic [DropW-1:0]   drop_above_bin,
  input  logic [ClampW-1:0]  clamp_bin,
  output logic [StatusW-1:0] res_status,
  output logic [BinW-1:0]    res_bin,
  output logic [TotalW-1:0]  res_total
);

  localparam int AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int PtrW  = $clog2(TableEntries + 1) + 1;
  localparam int HbW   = $clog2(HistBins);
  localparam int QCntW = $clog2(TimeW + 1);
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Captured beat.
  logic             opcode;
  logic [FlowW-1:0] flow_id;
  logic [TimeW-1:0] event_time;

  // Scan state.
  logic [PtrW-1:0]  ptr;
  logic [PtrW-1:0]  ptr_d;   // address of data now on the read port
  logic             rd_ok;
  logic             found;
  logic [AddrW-1:0] match_addr;
  logic             free_found;
  logic [AddrW-1:0] free_addr;

  // Valid bit memory and its clearing pass.
  logic             clearing;
  logic [AddrW-1:0] clr_addr;
  logic             valid_we;
  logic [AddrW-1:0] valid_waddr;
  logic             valid_wdata;
  logic             rd_valid;

  logic [FlowW-1:0] rd_flow;
  logic [TimeW-1:0] rd_time;
  logic [TimeW-1:0] start_time;

  // Divider state.
  logic [TimeW-1:0]  quo;
  logic [WidthW:0]   rem;
  logic [WidthW-1:0] divisor;
  logic [QCntW-1:0]  qcnt;

  logic [CountWidth-1:0] counters [HistBins];
  logic [HbW-1:0]        bin;
  logic [CountWidth-1:0] cnt_rd;

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] ptr_d_addr;
  logic             hit;
  logic [WidthW:0]  rem_sh;
  logic [WidthW:0]  rem_sub;
  logic [TimeW-1:0] quo_clamped;
  logic [HbW-1:0]   bin_next;

  assign rd_addr    = ptr[AddrW-1:0];
  assign ptr_d_addr = ptr_d[AddrW-1:0];
  assign hit        = rd_ok && rd_valid && (rd_flow == flow_id) && !found;

  flh_ram #(.Width(FlowW), .Depth(TableEntries)) u_flow (
    .clk(clk), .we(cmd.write_slot), .waddr(free_addr), .wdata(flow_id),
    .raddr(rd_addr), .rdata(rd_flow)
  );

  flh_ram #(.Width(TimeW), .Depth(TableEntries)) u_time (
    .clk(clk), .we(cmd.write_slot), .waddr(free_addr), .wdata(event_time),
    .raddr(rd_addr), .rdata(rd_time)
  );

  // Valid bits: cleared after reset, set on a new entry, dropped when counted.
  assign valid_we    = clearing || cmd.write_slot || cmd.free_slot;
  assign valid_waddr = clearing ? clr_addr : (cmd.write_slot ? free_addr : match_addr);
  assign valid_wdata = cmd.write_slot;

  flh_ram #(.Width(1), .Depth(TableEntries)) u_valid (
    .clk(clk), .we(valid_we), .waddr(valid_waddr), .wdata(valid_wdata),
    .raddr(rd_addr), .rdata(rd_valid)
  );

  // After reset, clear the valid bits one per cycle, from address zero to the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AddrW'(TableEntries - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode     <= in_opcode;
      flow_id    <= in_flow_id;
      event_time <= in_event_time;
    end
  end

  // Walk the table one entry a cycle; the read port is registered, so the compare uses ptr_d.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      ptr_d      <= '0;
      rd_ok      <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr        <= '0;
      rd_ok      <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_step) begin
      ptr_d <= ptr;
      rd_ok <= (ptr < PtrW'(TableEntries));
      if (ptr < PtrW'(TableEntries)) begin
        ptr <= ptr + 1'b1;
      end
      if (hit) begin
        found      <= 1'b1;
        match_addr <= ptr_d_addr;
        start_time <= rd_time;
      end
      if (rd_ok && !rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_addr  <= ptr_d_addr;
      end
    end
  end

  // Restoring divide, one quotient bit a cycle.
  assign rem_sh  = {rem[WidthW-1:0], quo[TimeW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo     <= event_time - start_time;
      rem     <= '0;
      divisor <= (bin_width_ns == '0) ? WidthW'(1) : bin_width_ns;
      qcnt    <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[WidthW]) begin
        rem <= rem_sub;
        quo <= {quo[TimeW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[TimeW-2:0], 1'b0};
      end
      qcnt <= qcnt + 1'b1;
    end
  end

  // Clamp the quotient, then keep it inside the histogram.
  always_comb begin
    quo_clamped = (quo > TimeW'(clamp_bin)) ? TimeW'(clamp_bin) : quo;
    if (quo_clamped >= TimeW'(HistBins)) begin
      bin_next = HbW'(HistBins - 1);
    end else begin
      bin_next = quo_clamped[HbW-1:0];
    end
  end

  // Histogram counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HistBins; i++) begin
        counters[i] <= '0;
      end
    end else if (cmd.hist_rd) begin
      bin    <= bin_next;
      cnt_rd <= counters[bin_next];
    end else if (cmd.hist_wr) begin
      if (cnt_rd != CountMax) begin
        counters[bin] <= cnt_rd + 1'b1;
        res_total     <= TotalW'(cnt_rd + 1'b1);
      end else begin
        res_total <= TotalW'(cnt_rd);
      end
      res_bin    <= BinW'(bin);
      res_status <= StCounted;
    end
    if (!rst && cmd.set_status) begin
      res_status <= cmd.status;
      res_bin    <= '0;
      res_total  <= '0;
    end
  end

  assign stat.clearing  = clearing;
  assign stat.op_end    = opcode;
  assign stat.scan_done = rd_ok == 1'b0 && ptr >= PtrW'(TableEntries);
  assign stat.rd_ok     = rd_ok;
  assign stat.match     = found;
  assign stat.have_free = free_found;
  assign stat.div_done  = (qcnt == QCntW'(TimeW));
  assign stat.out_range = (quo > TimeW'(drop_above_bin));

  `ASSERT_IMPL(a_no_dual_write, clk, rst, cmd.write_slot, !cmd.free_slot)
  `ASSERT_IMPL(a_no_write_while_clearing, clk, rst, clearing,
               !(cmd.write_slot || cmd.free_slot))

endmodule

[sv/flh_ctrl.sv]
`include "assert_macros.svh"

module flh_ctrl import flh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output flh_cmd_t  cmd,
  input  flh_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_DIV, S_HRD, S_HWR, S_OUT
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  // Sequence one event at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: if (!stat.clearing) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_SCAN;
        S_SCAN: begin
          if (stat.scan_done) begin
            if (!stat.op_end) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else if (stat.match) begin
              state <= S_DIV;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            if (stat.out_range) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              state <= S_HRD;
            end
          end
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode commands from state and status.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLR: ;
      S_IDLE: begin
        cmd.load       = in_valid;
        cmd.scan_start = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = !stat.scan_done;
        if (stat.scan_done) begin
          cmd.set_status = !(stat.op_end && stat.match);
          if (!stat.op_end) begin
            if (stat.match) begin
              cmd.status = StPresent;
            end else if (stat.have_free) begin
              cmd.status     = StStarted;
              cmd.write_slot = 1'b1;
            end else begin
              cmd.status = StFull;
            end
          end else begin
            cmd.status    = StUnmatched;
            cmd.div_start = stat.match;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = !stat.div_done;
        if (stat.div_done && stat.out_range) begin
          cmd.set_status = 1'b1;
          cmd.status     = StRange;
        end
      end
      S_HRD: cmd.hist_rd = 1'b1;
      S_HWR: begin
        cmd.hist_wr   = 1'b1;
        cmd.free_slot = 1'b1;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_only_in_out, clk, rst, out_valid, state == S_OUT)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && out_stall, out_valid)

endmodule

[bench/flow_latency_histogram_unit_test.sv]
`timescale 1ns / 1ps

module flow_latency_histogram_unit_test;
  import flh_pkg::*;

  localparam int Entries   = TableEntriesDef;
  localparam int Bins      = HistBinsDef;
  localparam int PoolSize  = 24;
  localparam int CycleCap  = 30000000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic             op;
    logic [FlowW-1:0] id;
    logic [TimeW-1:0] t;
  } event_t;

  typedef struct packed {
    logic [StatusW-1:0] st;
    logic [BinW-1:0]    bin;
    logic [TotalW-1:0]  total;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = 1'b0;
  logic [FlowW-1:0]   flow_id = '0;
  logic [TimeW-1:0]   event_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [BinW-1:0]    bin_index;
  logic [TotalW-1:0]  bin_total;

  flow_latency_histogram_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .flow_id(flow_id),
    .event_time(event_time), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .bin_index(bin_index), .bin_total(bin_total)
  );

  // Shadow copy of the block state
  logic [WidthW-1:0] width_reg;
  logic [DropW-1:0]  drop_reg;
  logic [ClampW-1:0] clamp_reg;
  logic              tbl_valid [Entries];
  logic [FlowW-1:0]  tbl_flow  [Entries];
  logic [TimeW-1:0]  tbl_start [Entries];
  logic [31:0]       hist      [Bins];

  event_t   pending_events[$];
  outcome_t expected_outcomes[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     hold_send = 1'b0;
  int       errors = 0;
  int       cycles = 0;

  // Flow pool used by the random part
  logic [FlowW-1:0] pool_id [PoolSize];
  logic [TimeW-1:0] pool_t  [PoolSize];

  function automatic outcome_t histogram_step(event_t e);
    int hit;
    int fr;
    logic [TimeW-1:0] w;
    logic [TimeW-1:0] q;
    outcome_t r;
    r = '0;
    hit = -1;
    fr = -1;
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i] && tbl_flow[i] == e.id) begin
        hit = i;
        break;
      end
    end
    if (!e.op) begin
      if (hit >= 0) begin
        r.st = StPresent;
      end else begin
        for (int i = 0; i < Entries; i++) begin
          if (!tbl_valid[i]) begin
            fr = i;
            break;
          end
        end
        if (fr < 0) begin
          r.st = StFull;
        end else begin
          tbl_valid[fr] = 1'b1;
          tbl_flow[fr] = e.id;
          tbl_start[fr] = e.t;
          r.st = StStarted;
        end
      end
    end else if (hit < 0) begin
      r.st = StUnmatched;
    end else begin
      w = (width_reg == 0) ? 64'd1 : TimeW'(width_reg);
      q = (e.t - tbl_start[hit]) / w;
      if (q > TimeW'(drop_reg)) begin
        r.st = StRange;
      end else begin
        if (q > TimeW'(clamp_reg)) q = TimeW'(clamp_reg);
        if (q >= TimeW'(Bins)) q = TimeW'(Bins - 1);
        if (hist[q] != 32'hFFFF_FFFF) hist[q] = hist[q] + 32'd1;
        r.st = StCounted;
        r.bin = q[BinW-1:0];
        r.total = hist[q];
        tbl_valid[hit] = 1'b0;
      end
    end
    return r;
  endfunction

  // Clock and cycle limit
  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Driver: launch the next beat, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_outcomes.push_back(histogram_step('{opcode, flow_id, event_time}));
      if (!in_valid || !in_stall) begin
        if (pending_events.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          event_t e;
          e = pending_events.pop_front();
          in_valid <= 1'b1;
          opcode <= e.op;
          flow_id <= e.id;
          event_time <= e.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall and monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result beat status=%0d", status);
          errors = errors + 1;
        end else begin
          outcome_t x;
          x = expected_outcomes.pop_front();
          if (status !== x.st) begin
            $error("status expected %0d actual %0d", x.st, status);
            errors = errors + 1;
          end
          if (bin_index !== x.bin) begin
            $error("bin_index expected %0d actual %0d", x.bin, bin_index);
            errors = errors + 1;
          end
          if (bin_total !== x.total) begin
            $error("bin_total expected %0d actual %0d", x.total, bin_total);
            errors = errors + 1;
          end
        end
      end
    end
  end

  task automatic push_event(logic op, logic [FlowW-1:0] id, logic [TimeW-1:0] t);
    pending_events.push_back('{op, id, t});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || expected_outcomes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgBinWidth: width_reg = val[WidthW-1:0];
      CfgDrop:     drop_reg = val[DropW-1:0];
      CfgClamp:    clamp_reg = val[ClampW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [TimeW-1:0] pick_delay();
    logic [TimeW-1:0] w;
    logic [TimeW-1:0] k;
    w = (width_reg == 0) ? 64'd1 : TimeW'(width_reg);
    case ($urandom_range(3))
      0: k = TimeW'($urandom_range(20));
      1: return {$urandom, $urandom};
      2: k = TimeW'($urandom_range(3));
      default: k = TimeW'($urandom_range(60, 45));
    endcase
    return k * w + ({$urandom, $urandom} % w);
  endfunction

  // Mostly start/end pairs over a small flow pool, some noise
  task automatic random_events(int n);
    int k;
    logic [TimeW-1:0] t;
    for (int i = 0; i < PoolSize; i++) pool_id[i] = $urandom;
    pool_id[0] = '0;
    pool_id[1] = '1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        push_event(1'($urandom_range(1)), $urandom, {$urandom, $urandom});
      end else begin
        k = $urandom_range(PoolSize - 1);
        if ($urandom_range(1) == 0) begin
          t = {$urandom, $urandom};
          pool_t[k] = t;
          push_event(1'b0, pool_id[k], t);
        end else begin
          push_event(1'b1, pool_id[k], pool_t[k] + pick_delay());
        end
      end
    end
  endtask

  initial begin
    width_reg = BinWidthRst;
    drop_reg = DropRst;
    clamp_reg = ClampRst;
    for (int i = 0; i < Entries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_flow[i] = '0;
      tbl_start[i] = '0;
    end
    for (int i = 0; i < Bins; i++) hist[i] = '0;
    for (int i = 0; i < PoolSize; i++) pool_t[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: start, match, duplicate, unmatched, wrap, out of range
    send_idle_pct = 26;
    recv_idle_pct = 51;
    push_event(1'b0, 32'h0, 64'h0);
    push_event(1'b0, 32'h0, 64'h5);
    push_event(1'b1, 32'h0, 64'd500000000);
    push_event(1'b1, 32'h0, 64'd500000000);
    push_event(1'b1, 32'hFFFF_FFFF, '1);
    push_event(1'b0, 32'hFFFF_FFFF, '1);
    push_event(1'b1, 32'hFFFF_FFFF, 64'd250000000);
    push_event(1'b0, 32'hA5A5_5A5A, 64'd1000);
    push_event(1'b1, 32'hA5A5_5A5A, 64'd1000 + 64'd5100000000);
    push_event(1'b1, 32'hA5A5_5A5A, 64'd1000 + 64'd5099999999);
    push_event(1'b0, 32'h5A5A_A5A5, 64'd7);
    push_event(1'b1, 32'h5A5A_A5A5, 64'd7 + 64'd1500000000);
    push_event(1'b0, 32'h1234_5678, 64'h8000_0000_0000_0000);
    push_event(1'b1, 32'h1234_5678, 64'h8000_0000_0000_0000 + 64'd99999999);
    push_event(1'b1, 32'h1234_5678, 64'h7FFF_FFFF_FFFF_FFFF);
    random_events(40);
    // Hold off new beats until everything is back
    hold_send = 1'b1;
    do @(posedge clk);
    while (in_valid || expected_outcomes.size() != 0);
    hold_send = 1'b0;
    random_events(20);
    wait_drained();

    // Small width, wide drop, top clamp
    write_reg(CfgBinWidth, 40'd1000);
    write_reg(CfgDrop, 40'd255);
    write_reg(CfgClamp, 40'd15);
    send_idle_pct = 51;
    recv_idle_pct = 26;
    random_events(40);
    wait_drained();

    // Zero width, zero drop and clamp; unused index
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgBinWidth, 40'd0);
    write_reg(CfgDrop, 40'd0);
    write_reg(CfgClamp, 40'd0);
    write_reg(CfgUnused, '1);
    random_events(25);
    wait_drained();

    // Widest bin, clamp above drop
    write_reg(CfgBinWidth, 40'hFF_FFFF_FFFF);
    write_reg(CfgDrop, 40'd3);
    write_reg(CfgClamp, 40'd12);
    random_events(25);
    wait_drained();

    write_reg(CfgBinWidth, 40'd37);
    write_reg(CfgDrop, 40'd40);
    write_reg(CfgClamp, 40'd5);
    random_events(30);
    wait_drained();

    // Fill the table to overflow, then end a few of the flows
    for (int i = 0; i < Entries + 4; i++) push_event(1'b0, 32'h4000_0000 + i, 64'd100 * i);
    for (int i = 0; i < 16; i++)
      push_event(1'b1, 32'h4000_0000 + i, 64'd100 * i + 64'($urandom_range(20000)));
    wait_drained();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/flh_pkg.sv
sv/flh_ram.sv
sv/flh_datapath.sv
sv/flh_ctrl.sv
sv/flow_latency_histogram_unit.sv
bench/flow_latency_histogram_unit_test.sv
